@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent assertions used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/udsdl_pkg.sv @@
// ----------------------------------------------------------------------------
// udsdl_pkg
// Types and constants of the diagnostic download request dispatcher.
// ----------------------------------------------------------------------------
package udsdl_pkg;

   // Service identifiers
   localparam logic [7:0] SID_OFFSET   = 8'h40;
   localparam logic [7:0] SID_SESSION  = 8'h10;
   localparam logic [7:0] SID_ERASE    = 8'h31;
   localparam logic [7:0] SID_DOWNLOAD = 8'h34;
   localparam logic [7:0] SID_TRANSFER = 8'h36;
   localparam logic [7:0] SID_EXIT     = 8'h37;
   localparam logic [7:0] SID_RESET    = 8'h11;

   // Single-frame lengths and subfunctions
   localparam logic [7:0] LEN_SESSION  = 8'h02;
   localparam logic [7:0] LEN_ERASE    = 8'h04;
   localparam logic [7:0] LEN_DOWNLOAD = 8'h07;
   localparam logic [7:0] LEN_TRANSFER = 8'h06;
   localparam logic [7:0] LEN_EXIT     = 8'h01;
   localparam logic [7:0] SUB_PROG     = 8'h02;
   localparam logic [7:0] SUB_RESET    = 8'h01;
   localparam logic [7:0] ERASE_ROUTINE = 8'h06;
   localparam logic [7:0] ADDR_TOP_BYTE = 8'h08;

   // Flash actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_SESSION = 3'd1;
   localparam logic [2:0] ACT_ERASE   = 3'd2;
   localparam logic [2:0] ACT_PROGRAM = 3'd3;
   localparam logic [2:0] ACT_RESET   = 3'd4;

   // Configuration registers
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERASE_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERASE_END   = 1'b1;
   localparam logic [31:0] ERASE_START_RST = 32'h0800_0000;
   localparam logic [31:0] ERASE_END_RST   = 32'h0800_3FFF;

   typedef struct packed {
      logic [10:0] can_id;
      logic [7:0]  req_byte0;
      logic [7:0]  req_byte1;
      logic [7:0]  req_byte2;
      logic [7:0]  req_byte3;
      logic [7:0]  req_byte4;
      logic [7:0]  req_byte5;
      logic [7:0]  req_byte6;
      logic [7:0]  req_byte7;
   } req_type;

   typedef struct packed {
      logic [10:0] resp_id;
      logic [7:0]  resp_byte0;
      logic [7:0]  resp_byte1;
      logic [7:0]  resp_byte2;
      logic [7:0]  resp_byte3;
      logic [7:0]  resp_byte4;
      logic [7:0]  resp_byte5;
      logic [7:0]  resp_byte6;
      logic [7:0]  resp_byte7;
      logic [2:0]  flash_action;
      logic [31:0] flash_addr;
      logic [31:0] flash_data;
   } rsp_type;

   // Decode outcome handed back to the top level
   typedef struct packed {
      logic        hit;        // frame matched a service, send a response
      logic        load_ptr;   // request download: reload pointer, clear count
      logic        step_ptr;   // transfer data: advance pointer and count
      logic [31:0] load_addr;
      rsp_type     rsp;
   } dec_type;

endpackage

@@ rtl/udsdl_decode.sv @@
// ----------------------------------------------------------------------------
// udsdl_decode
// Matches one request frame and builds its response and flash command.
// ----------------------------------------------------------------------------
module udsdl_decode (
   input  udsdl_pkg::req_type req,
   input  logic [31:0]        erase_start,
   input  logic [31:0]        erase_end,
   input  logic [31:0]        download_address,
   output udsdl_pkg::dec_type dec
);
   import udsdl_pkg::*;

   logic echo;

   always_comb begin
      dec  = '0;
      echo = 1'b0;

      dec.rsp.resp_id    = req.can_id + 11'd1;
      dec.rsp.resp_byte0 = req.req_byte0;
      dec.rsp.resp_byte1 = req.req_byte1 + SID_OFFSET;
      dec.rsp.resp_byte2 = req.req_byte2;
      dec.load_addr      = {ADDR_TOP_BYTE, req.req_byte4, req.req_byte5, req.req_byte6};

      priority if (req.req_byte1 == SID_SESSION && req.req_byte2 == SUB_PROG &&
                   req.req_byte0 == LEN_SESSION) begin
         dec.hit              = 1'b1;
         dec.rsp.flash_action = ACT_SESSION;
      end else if (req.req_byte1 == SID_ERASE && req.req_byte0 == LEN_ERASE &&
                   req.req_byte2 == 8'h00 && req.req_byte3 == 8'h00 &&
                   req.req_byte4 == ERASE_ROUTINE) begin
         dec.hit              = 1'b1;
         echo                 = 1'b1;
         dec.rsp.flash_action = ACT_ERASE;
         dec.rsp.flash_addr   = erase_start;
         dec.rsp.flash_data   = erase_end;
      end else if (req.req_byte1 == SID_DOWNLOAD && req.req_byte0 == LEN_DOWNLOAD) begin
         dec.hit      = 1'b1;
         echo         = 1'b1;
         dec.load_ptr = 1'b1;
      end else if (req.req_byte1 == SID_TRANSFER && req.req_byte0 == LEN_TRANSFER) begin
         dec.hit              = 1'b1;
         dec.step_ptr         = 1'b1;
         dec.rsp.flash_action = ACT_PROGRAM;
         dec.rsp.flash_addr   = download_address;
         // little-endian word from bytes 3..6
         dec.rsp.flash_data   = {req.req_byte6, req.req_byte5, req.req_byte4,
                                 req.req_byte3};
      end else if (req.req_byte1 == SID_EXIT && req.req_byte0 == LEN_EXIT) begin
         dec.hit = 1'b1;
      end else if (req.req_byte1 == SID_RESET && req.req_byte2 == SUB_RESET) begin
         dec.hit              = 1'b1;
         echo                 = 1'b1;
         dec.rsp.flash_action = ACT_RESET;
      end else begin
         // no service matched: drop the frame
         dec.hit = 1'b0;
      end

      if (echo) begin
         dec.rsp.resp_byte3 = req.req_byte3;
         dec.rsp.resp_byte4 = req.req_byte4;
         dec.rsp.resp_byte5 = req.req_byte5;
         dec.rsp.resp_byte6 = req.req_byte6;
         dec.rsp.resp_byte7 = req.req_byte7;
      end
   end

endmodule

@@ rtl/uds_download_request_dispatch.sv @@
// ----------------------------------------------------------------------------
// uds_download_request_dispatch
// Decodes single-frame flash download requests into responses and flash
// commands, keeping the download pointer and transferred word count.
//
//   channel  ports                          direction  transfer
//   request  req_valid/req_ready/req_data   in         valid & ready
//   response rsp_valid/rsp_ready/rsp_data   out        valid & ready
//   csr      csr_wen/csr_index/csr_wdata    in         csr_wen
//
// One frame is taken every cycle while req_ready is high; a response leaves
// through the input register, then the result register, with the one-level
// decode between them. Frames that match no service are dropped with no
// transfer. A stalled response holds the result register and, once the
// input register is also full, drops req_ready. Synchronous reset empties
// both stages, clears the pointer and count and loads the erase range.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uds_download_request_dispatch (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  udsdl_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output udsdl_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_wen,
   input  logic [udsdl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                            csr_wdata
);
   import udsdl_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_data_ff, s1_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [31:0] download_address_ff, download_address_in;
   logic [31:0] words_written_ff, words_written_in;
   logic [31:0] erase_start_ff, erase_start_in;
   logic [31:0] erase_end_ff, erase_end_in;

   dec_type     dec;
   logic        s1_advance;
   logic        s1_fire;

   udsdl_decode u_decode (
      .req              (s1_data_ff),
      .erase_start      (erase_start_ff),
      .erase_end        (erase_end_ff),
      .download_address (download_address_ff),
      .dec              (dec)
   );

   // stage 1 moves on when the result register is free or being drained
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff && dec.hit;
         rsp_data_in  = dec.rsp;
      end
   end

   always_comb begin
      download_address_in = download_address_ff;
      words_written_in    = words_written_ff;
      if (s1_fire && dec.load_ptr) begin
         download_address_in = dec.load_addr;
         words_written_in    = '0;
      end else if (s1_fire && dec.step_ptr) begin
         download_address_in = download_address_ff + 32'd4;
         words_written_in    = words_written_ff + 32'd1;
      end
   end

   always_comb begin
      erase_start_in = erase_start_ff;
      erase_end_in   = erase_end_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_ERASE_START: erase_start_in = csr_wdata;
            CSR_ERASE_END:   erase_end_in   = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         download_address_ff <= '0;
         words_written_ff    <= '0;
         erase_start_ff      <= ERASE_START_RST;
         erase_end_ff        <= ERASE_END_RST;
      end else begin
         s1_valid_ff         <= s1_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         download_address_ff <= download_address_in;
         words_written_ff    <= words_written_in;
         erase_start_ff      <= erase_start_in;
         erase_end_ff        <= erase_end_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_SAME(a_hold_on_stall, clock, reset, rsp_valid_ff && !rsp_ready, !s1_fire)
   `ASSERT_NEXT(a_step_count, clock, reset, s1_fire && dec.step_ptr && !dec.load_ptr,
                words_written_ff == $past(words_written_ff) + 32'd1)
   `ASSERT_NEXT(a_step_addr, clock, reset, s1_fire && dec.step_ptr && !dec.load_ptr,
                download_address_ff == $past(download_address_ff) + 32'd4)
   `ASSERT_NEXT(a_load_clears, clock, reset, s1_fire && dec.load_ptr,
                words_written_ff == 32'd0)
   `ASSERT_NEXT(a_program_rsp, clock, reset, s1_fire && dec.step_ptr,
                rsp_valid_ff && rsp_data_ff.flash_action == ACT_PROGRAM)

endmodule

@@ sim/dispatch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dispatch_checker
// Watches the request, response and register ports of the download request
// dispatcher, predicts each response from its own copy of the erase range and
// download pointer, and compares every response transfer field by field.
// ----------------------------------------------------------------------------
module dispatch_checker
   import udsdl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   output int                     errors,
   output int                     pending
);

   logic [31:0] range_start;
   logic [31:0] range_end;
   logic [31:0] load_pointer;
   logic [31:0] word_count;
   rsp_type     awaited_responses[$];

   initial errors = 0;

   // Works out the response to one frame and reloads or advances the download pointer.
   function automatic bit decode_request(input req_type f, output rsp_type r);
      bit hit;
      bit echo;
      hit = 1'b1;
      echo = 1'b0;
      r = '0;
      r.resp_id = f.can_id + 11'd1;
      r.resp_byte0 = f.req_byte0;
      r.resp_byte1 = f.req_byte1 + SID_OFFSET;
      r.resp_byte2 = f.req_byte2;
      r.flash_action = ACT_NONE;
      if (f.req_byte1 == SID_SESSION && f.req_byte2 == SUB_PROG &&
          f.req_byte0 == LEN_SESSION) begin
         r.flash_action = ACT_SESSION;
      end else if (f.req_byte1 == SID_ERASE && f.req_byte0 == LEN_ERASE &&
                   f.req_byte2 == 8'h00 && f.req_byte3 == 8'h00 &&
                   f.req_byte4 == ERASE_ROUTINE) begin
         echo = 1'b1;
         r.flash_action = ACT_ERASE;
         r.flash_addr = range_start;
         r.flash_data = range_end;
      end else if (f.req_byte1 == SID_DOWNLOAD && f.req_byte0 == LEN_DOWNLOAD) begin
         echo = 1'b1;
         load_pointer = {ADDR_TOP_BYTE, f.req_byte4, f.req_byte5, f.req_byte6};
         word_count = '0;
      end else if (f.req_byte1 == SID_TRANSFER && f.req_byte0 == LEN_TRANSFER) begin
         r.flash_action = ACT_PROGRAM;
         r.flash_addr = load_pointer;
         r.flash_data = {f.req_byte6, f.req_byte5, f.req_byte4, f.req_byte3};
         load_pointer = load_pointer + 32'd4;
         word_count = word_count + 32'd1;
      end else if (f.req_byte1 == SID_EXIT && f.req_byte0 == LEN_EXIT) begin
         r.flash_action = ACT_NONE;
      end else if (f.req_byte1 == SID_RESET && f.req_byte2 == SUB_RESET) begin
         echo = 1'b1;
         r.flash_action = ACT_RESET;
      end else begin
         hit = 1'b0;
      end
      if (echo) begin
         r.resp_byte3 = f.req_byte3;
         r.resp_byte4 = f.req_byte4;
         r.resp_byte5 = f.req_byte5;
         r.resp_byte6 = f.req_byte6;
         r.resp_byte7 = f.req_byte7;
      end
      return hit;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      if (reset) begin
         range_start = ERASE_START_RST;
         range_end = ERASE_END_RST;
         load_pointer = '0;
         word_count = '0;
         awaited_responses.delete();
         pending <= 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_ERASE_START)
               range_start = csr_wdata;
            else if (csr_index == CSR_ERASE_END)
               range_end = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (awaited_responses.size() == 0) begin
               $display("%0t: response expected none, got 0x%0h", $time, got);
               errors++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("resp_id", want.resp_id, got.resp_id);
               check_field("resp_byte0", want.resp_byte0, got.resp_byte0);
               check_field("resp_byte1", want.resp_byte1, got.resp_byte1);
               check_field("resp_byte2", want.resp_byte2, got.resp_byte2);
               check_field("resp_byte3", want.resp_byte3, got.resp_byte3);
               check_field("resp_byte4", want.resp_byte4, got.resp_byte4);
               check_field("resp_byte5", want.resp_byte5, got.resp_byte5);
               check_field("resp_byte6", want.resp_byte6, got.resp_byte6);
               check_field("resp_byte7", want.resp_byte7, got.resp_byte7);
               check_field("flash_action", want.flash_action, got.flash_action);
               check_field("flash_addr", want.flash_addr, got.flash_addr);
               check_field("flash_data", want.flash_data, got.flash_data);
            end
         end
         if (req_valid && req_ready) begin
            if (decode_request(req_data, want))
               awaited_responses.push_back(want);
         end
         pending <= awaited_responses.size();
      end
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the download request dispatcher with directed and random request
// frames under random gaps and response stalls, steps the erase range through
// several settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import udsdl_pkg::*;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_ITEMS     = 340;

   typedef enum int {
      SVC_SESSION, SVC_ERASE, SVC_DOWNLOAD, SVC_TRANSFER, SVC_EXIT, SVC_RESET, SVC_NOISE
   } service_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;
   int                     errors;
   int                     pending;

   int  hold_off_count = 0;
   int  answered = 0;
   int  mode_left = 0;
   bit  no_gaps = 1'b0;

   uds_download_request_dispatch dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dispatch_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Random frame content with the bytes that select one service forced.
   function automatic req_type build_frame(input service_type svc);
      logic [95:0] raw;
      req_type     f;
      raw = {$urandom, $urandom, $urandom};
      f = raw[74:0];
      case (svc)
         SVC_SESSION: begin
            f.req_byte0 = LEN_SESSION;
            f.req_byte1 = SID_SESSION;
            f.req_byte2 = SUB_PROG;
         end
         SVC_ERASE: begin
            f.req_byte0 = LEN_ERASE;
            f.req_byte1 = SID_ERASE;
            f.req_byte2 = 8'h00;
            f.req_byte3 = 8'h00;
            f.req_byte4 = ERASE_ROUTINE;
         end
         SVC_DOWNLOAD: begin
            f.req_byte0 = LEN_DOWNLOAD;
            f.req_byte1 = SID_DOWNLOAD;
         end
         SVC_TRANSFER: begin
            f.req_byte0 = LEN_TRANSFER;
            f.req_byte1 = SID_TRANSFER;
         end
         SVC_EXIT: begin
            f.req_byte0 = LEN_EXIT;
            f.req_byte1 = SID_EXIT;
         end
         SVC_RESET: begin
            f.req_byte1 = SID_RESET;
            f.req_byte2 = SUB_RESET;
         end
         default: ;
      endcase
      return f;
   endfunction

   // Called at a clock edge; returns at the edge where the frame transfers.
   task automatic send_frame(input req_type f);
      int gap;
      int pick;
      if (mode_left == 0) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      gap = 0;
      if (!no_gaps) begin
         pick = $urandom_range(0, 99);
         if (pick >= 92)
            gap = $urandom_range(8, 30);
         else if (pick >= 60)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_service(input service_type svc);
      send_frame(build_frame(svc));
      answered++;
   endtask

   // Lower valid and wait until every expected response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_range(input logic [31:0] first, input logic [31:0] last);
      csr_wen <= 1'b1;
      csr_index <= CSR_ERASE_START;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_ERASE_END;
      csr_wdata <= last;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic run_traffic(input int quota);
      int          target;
      int          pick;
      int          n;
      logic [7:0]  flip;
      req_type     f;
      target = answered + quota;
      while (answered < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_service(SVC_SESSION);
            send_service(SVC_ERASE);
            send_service(SVC_DOWNLOAD);
            n = $urandom_range(1, 12);
            repeat (n) send_service(SVC_TRANSFER);
            send_service(SVC_EXIT);
            if ($urandom_range(0, 3) == 0)
               send_service(SVC_RESET);
         end else if (pick < 80) begin
            send_service(service_type'($urandom_range(0, 5)));
         end else if (pick < 92) begin
            // corrupt one of bytes 0 to 4 of an otherwise valid request
            f = build_frame(service_type'($urandom_range(0, 5)));
            flip = $urandom_range(1, 255);
            case ($urandom_range(0, 4))
               0: f.req_byte0 ^= flip;
               1: f.req_byte1 ^= flip;
               2: f.req_byte2 ^= flip;
               3: f.req_byte3 ^= flip;
               default: f.req_byte4 ^= flip;
            endcase
            send_frame(f);
         end else begin
            send_frame(build_frame(SVC_NOISE));
         end
      end
   endtask

   initial begin : response_sink
      int served;
      int steady_left;
      int n;
      bit steady;
      served = 0;
      steady_left = 0;
      steady = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady_left == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            steady_left = $urandom_range(20, 120);
         end
         steady_left--;
         if (hold_off_count != served) begin
            // hold off long enough for both stages to fill and req_ready to drop
            served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!steady && $urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int p;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wen <= 1'b0;
      csr_index <= CSR_ERASE_START;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // transfer ahead of any download programs at pointer zero
      send_frame({11'h000, LEN_TRANSFER, SID_TRANSFER, 8'h00, 32'h0000_0000, 8'h00});
      // id 2047 wraps to 0
      send_frame({11'h7FF, LEN_SESSION, SID_SESSION, SUB_PROG, 40'hFF_FFFF_FFFF});
      send_frame({11'h000, LEN_SESSION, SID_SESSION, SUB_PROG, 40'h00_0000_0000});
      send_frame({11'h123, LEN_ERASE, SID_ERASE, 8'h00, 8'h00, ERASE_ROUTINE, 24'hFF_FFFF});
      send_frame({11'h7FF, LEN_DOWNLOAD, SID_DOWNLOAD, 8'hFF, 8'hFF, 24'hFF_FFFF, 8'hFF});
      send_frame({11'h555, LEN_TRANSFER, SID_TRANSFER, 8'hFF, 32'hFFFF_FFFF, 8'hFF});
      send_frame({11'h2AA, LEN_TRANSFER, SID_TRANSFER, 8'h00, 32'h0000_0000, 8'h00});
      send_frame({11'h001, LEN_DOWNLOAD, SID_DOWNLOAD, 8'h00, 8'h00, 24'h00_0000, 8'h00});
      send_frame({11'h002, LEN_TRANSFER, SID_TRANSFER, 8'h5A, 32'h0403_0201, 8'hA5});
      send_frame({11'h003, LEN_EXIT, SID_EXIT, 8'hFF, 40'hFF_FFFF_FFFF});
      // reset request takes any length byte
      send_frame({11'h004, 8'h00, SID_RESET, SUB_RESET, 40'hFF_FFFF_FFFF});
      send_frame({11'h7FE, 8'hFF, SID_RESET, SUB_RESET, 40'h01_2345_6789});
      // near misses: no response, pointer untouched
      send_frame({11'h005, 8'h03, SID_SESSION, SUB_PROG, 40'h00_0000_0000});
      send_frame({11'h006, LEN_SESSION, SID_SESSION, SUB_RESET, 40'h00_0000_0000});
      send_frame({11'h007, LEN_ERASE, SID_ERASE, 8'h00, 8'h00, 8'h07, 24'h00_0000});
      send_frame({11'h008, LEN_ERASE, SID_ERASE, 8'h00, 8'h01, ERASE_ROUTINE, 24'h00_0000});
      send_frame({11'h009, LEN_ERASE, SID_ERASE, 8'h01, 8'h00, ERASE_ROUTINE, 24'h00_0000});
      send_frame({11'h00A, LEN_TRANSFER, SID_DOWNLOAD, 48'h0000_0000_0000});
      send_frame({11'h00B, LEN_DOWNLOAD, SID_TRANSFER, 48'hFFFF_FFFF_FFFF});
      send_frame({11'h00C, 8'h00, SID_EXIT, 48'h0000_0000_0000});
      send_frame({11'h00D, LEN_SESSION, SID_RESET, SUB_PROG, 40'h00_0000_0000});
      send_frame({11'h000, 64'h0000_0000_0000_0000});
      send_frame({11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF});
      send_frame({11'h00E, LEN_TRANSFER, SID_TRANSFER, 8'h00, 32'h8000_0001, 8'h00});

      for (p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: write_range(32'h0000_0000, 32'hFFFF_FFFF);
            1: write_range(32'hFFFF_FFFF, 32'h0000_0000);
            2: write_range($urandom, $urandom);
            default: write_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
         endcase
         if (p == 0 || p == 2)
            hold_off_count <= hold_off_count + 1;
         run_traffic(PHASE_ITEMS);
      end
      drain();
      repeat (8) @(posedge clock);

      if (errors == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/udsdl_pkg.sv
rtl/udsdl_decode.sv
rtl/uds_download_request_dispatch.sv
sim/dispatch_checker.sv
sim/tb_top.sv
